FILE: rtl/lcdst_pkg.sv
// Shared types and constants for the LCD scanline timer and its register file.
// No dependencies; every other file imports this package.
package lcdst_pkg;

    // Field widths.
    localparam int CMD_W  = 2;
    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int DOT_W  = 9;
    localparam int LINE_W = 8;
    localparam int EN_W   = 4;

    // Frame geometry.
    localparam logic [DOT_W-1:0]  DOTS_LINE    = 9'd456;
    localparam logic [LINE_W-1:0] LINES_FRAME  = 8'd154;
    localparam logic [LINE_W-1:0] VBLANK_START = 8'd144;
    localparam logic [DOT_W-1:0]  DOT_LAST     = DOTS_LINE - 9'd1;
    localparam logic [LINE_W-1:0] LINE_LAST    = LINES_FRAME - 8'd1;

    // Mode boundaries within a line.
    localparam logic [DOT_W-1:0] OAM_DOTS  = 9'd80;
    localparam logic [DOT_W-1:0] XFER_DOTS = 9'd172;
    localparam logic [DOT_W-1:0] XFER_END  = OAM_DOTS + XFER_DOTS;

    // Register addresses.
    localparam logic [ADDR_W-1:0] ADDR_CTRL  = 16'hFF40;
    localparam logic [ADDR_W-1:0] ADDR_STAT  = 16'hFF41;
    localparam logic [ADDR_W-1:0] ADDR_SCY   = 16'hFF42;
    localparam logic [ADDR_W-1:0] ADDR_SCX   = 16'hFF43;
    localparam logic [ADDR_W-1:0] ADDR_LINE  = 16'hFF44;
    localparam logic [ADDR_W-1:0] ADDR_LYC   = 16'hFF45;
    localparam logic [ADDR_W-1:0] ADDR_BGP   = 16'hFF47;
    localparam logic [ADDR_W-1:0] ADDR_OBP0  = 16'hFF48;
    localparam logic [ADDR_W-1:0] ADDR_OBP1  = 16'hFF49;
    localparam logic [ADDR_W-1:0] ADDR_WY    = 16'hFF4A;
    localparam logic [ADDR_W-1:0] ADDR_WX    = 16'hFF4B;

    // Data constants.
    localparam logic [DATA_W-1:0] RDATA_UNMAPPED = 8'hFF;
    localparam int CTRL_ENABLE_BIT = 7;
    localparam int STAT_EN_LSB     = 3;

    // Status enable bit positions.
    localparam int EN_HBLANK = 0;
    localparam int EN_VBLANK = 1;
    localparam int EN_OAM    = 2;
    localparam int EN_LYC    = 3;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } cmd_t;

    // Display modes.
    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } mode_t;

    // Input item.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              vblank_irq;
        logic              stat_irq;
    } out_item_t;

    // Register file to timer.
    typedef struct packed {
        logic              display_on;
        logic              counter_clear;
        logic [EN_W-1:0]   stat_en;
        logic [LINE_W-1:0] line_compare;
    } timer_cfg_t;

    // Timer to register file.
    typedef struct packed {
        logic [LINE_W-1:0] line_count;
        logic              coincidence;
        mode_t             mode;
    } timer_status_t;

    // Mode derived from the counters.
    function automatic mode_t mode_of(logic [LINE_W-1:0] line, logic [DOT_W-1:0] dot);
        mode_t m;
        if (line >= VBLANK_START)
            m = MODE_VBLANK;
        else if (dot < OAM_DOTS)
            m = MODE_OAM;
        else if (dot < XFER_END)
            m = MODE_XFER;
        else
            m = MODE_HBLANK;
        return m;
    endfunction

endpackage

FILE: rtl/lcdst_timer.sv
// Dot and line counters, mode decode and interrupt pulse generation.
// Depends on lcdst_pkg.
module lcdst_timer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick,
    input  lcdst_pkg::timer_cfg_t cfg,
    output lcdst_pkg::timer_status_t status,
    output logic                  vblank_pulse,
    output logic                  stat_pulse
);
    import lcdst_pkg::*;

    logic [DOT_W-1:0]  dot_reg, dot_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              prev_reg, prev_next;
    logic [DOT_W-1:0]  dot_adv;
    logic [LINE_W-1:0] line_adv;
    logic              wrap;
    mode_t             mode_adv;
    logic              level;

    // Advanced counter values for an enabled tick.
    always_comb
    begin
        wrap     = (dot_reg >= DOT_LAST);
        dot_adv  = wrap ? '0 : dot_reg + 9'd1;
        line_adv = line_reg;
        if (wrap)
            line_adv = (line_reg >= LINE_LAST) ? '0 : line_reg + 8'd1;
        mode_adv = mode_of(line_adv, dot_adv);
        level = (cfg.stat_en[EN_HBLANK] && mode_adv == MODE_HBLANK)
             || (cfg.stat_en[EN_VBLANK] && mode_adv == MODE_VBLANK)
             || (cfg.stat_en[EN_OAM]    && mode_adv == MODE_OAM)
             || (cfg.stat_en[EN_LYC]    && line_adv == cfg.line_compare);
    end

    // Next state and interrupt pulses.
    always_comb
    begin
        dot_next     = dot_reg;
        line_next    = line_reg;
        prev_next    = prev_reg;
        vblank_pulse = 1'b0;
        stat_pulse   = 1'b0;
        if (cfg.counter_clear)
        begin
            dot_next  = '0;
            line_next = '0;
        end
        else if (tick)
        begin
            if (!cfg.display_on)
            begin
                dot_next  = '0;
                line_next = '0;
            end
            else
            begin
                dot_next     = dot_adv;
                line_next    = line_adv;
                prev_next    = level;
                vblank_pulse = wrap && (line_adv == VBLANK_START);
                stat_pulse   = level && !prev_reg;
            end
        end
    end

    // Counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg  <= '0;
            line_reg <= '0;
            prev_reg <= 1'b0;
        end
        else
        begin
            dot_reg  <= dot_next;
            line_reg <= line_next;
            prev_reg <= prev_next;
        end
    end

    // Status seen by bus reads reflects the current counters.
    assign status = {line_reg, line_reg == cfg.line_compare, mode_of(line_reg, dot_reg)};

`ifndef ASSERT_OFF
    a_dot_range: assert property (@(posedge clk) disable iff (!rst_n)
        dot_reg < DOTS_LINE)
        else $error("dot counter out of range");
    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg < LINES_FRAME)
        else $error("line counter out of range");
    a_vblank_entry: assert property (@(posedge clk) disable iff (!rst_n)
        vblank_pulse |=> (line_reg == VBLANK_START) && (dot_reg == '0))
        else $error("vblank pulse without entering the vblank line");
    a_stat_edge: assert property (@(posedge clk) disable iff (!rst_n)
        stat_pulse |=> prev_reg && !$past(prev_reg))
        else $error("status pulse without a rising level");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.counter_clear |=> (line_reg == '0) && (dot_reg == '0))
        else $error("counters not cleared on display off");
`endif

endmodule

FILE: rtl/lcdst_regfile.sv
// Register file: control, status enables, line compare and plain registers,
// with the read mux that composes the status byte. Depends on lcdst_pkg.
module lcdst_regfile (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic                        wr_en,
    input  logic [lcdst_pkg::ADDR_W-1:0] addr,
    input  logic [lcdst_pkg::DATA_W-1:0] wdata,
    input  lcdst_pkg::timer_status_t    status,
    output lcdst_pkg::timer_cfg_t       cfg,
    output logic [lcdst_pkg::DATA_W-1:0] rdata
);
    import lcdst_pkg::*;

    localparam int NUM_PLAIN = 7;
    localparam int PLAIN_IW  = $clog2(NUM_PLAIN);

    logic [DATA_W-1:0]   ctrl_reg, ctrl_next;
    logic [EN_W-1:0]     en_reg, en_next;
    logic [LINE_W-1:0]   lyc_reg, lyc_next;
    logic [DATA_W-1:0]   plain_reg [NUM_PLAIN];
    logic                plain_hit;
    logic [PLAIN_IW-1:0] plain_idx;
    logic                counter_clear;

    // Plain register slot decode.
    always_comb
    begin
        plain_hit = 1'b1;
        plain_idx = '0;
        case (addr)
            ADDR_SCY:  plain_idx = PLAIN_IW'(0);
            ADDR_SCX:  plain_idx = PLAIN_IW'(1);
            ADDR_BGP:  plain_idx = PLAIN_IW'(2);
            ADDR_OBP0: plain_idx = PLAIN_IW'(3);
            ADDR_OBP1: plain_idx = PLAIN_IW'(4);
            ADDR_WY:   plain_idx = PLAIN_IW'(5);
            ADDR_WX:   plain_idx = PLAIN_IW'(6);
            default:   plain_hit = 1'b0;
        endcase
    end

    // Register writes.
    always_comb
    begin
        ctrl_next = ctrl_reg;
        en_next   = en_reg;
        lyc_next  = lyc_reg;
        counter_clear = 1'b0;
        if (wr_en)
        begin
            case (addr)
                ADDR_CTRL:
                begin
                    ctrl_next     = wdata;
                    counter_clear = !wdata[CTRL_ENABLE_BIT];
                end
                ADDR_STAT: en_next  = wdata[STAT_EN_LSB +: EN_W];
                ADDR_LYC:  lyc_next = wdata;
                default:   ;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
            en_reg   <= '0;
            lyc_reg  <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
            en_reg   <= en_next;
            lyc_reg  <= lyc_next;
        end
    end

    // Plain registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLAIN; i++)
                plain_reg[i] <= '0;
        end
        else if (wr_en && plain_hit)
        begin
            plain_reg[plain_idx] <= wdata;
        end
    end

    // Read mux; only a read yields nonzero data.
    always_comb
    begin
        rdata = '0;
        if (rd_en)
        begin
            case (addr)
                ADDR_CTRL: rdata = ctrl_reg;
                ADDR_STAT: rdata = {1'b1, en_reg, status.coincidence, status.mode};
                ADDR_LINE: rdata = status.line_count;
                ADDR_LYC:  rdata = lyc_reg;
                default:   rdata = plain_hit ? plain_reg[plain_idx] : RDATA_UNMAPPED;
            endcase
        end
    end

    // Configuration seen by the timer: display enable, clear, enables, line compare.
    assign cfg = {ctrl_reg[CTRL_ENABLE_BIT], counter_clear, en_reg, lyc_reg};

endmodule

FILE: rtl/lcd_scanline_timer_regs_top.sv
// Top level of the LCD scanline timer with its register file.
// Depends on lcdst_pkg, lcdst_regfile and lcdst_timer.
//
// Usage:
//   Each input item on in_data is one command: a dot tick, a bus read or a
//   bus write, handed over with in_valid/in_ready. Every item produces
//   exactly one result item on out_data (read data and interrupt pulses),
//   handed over with out_valid/out_ready.
//   An accepted item is held in an input register; it is executed against
//   the timer and register state once the output register is free or
//   draining, and its result is captured in the output register, which
//   raises out_valid. One item is executed per cycle, so a new item can be
//   accepted in every cycle while the output side keeps up.
//   When the receiver stalls, the result stays in the output register and
//   the item behind it waits in the input register; in_ready drops only
//   while both registers are full and out_ready is low.
//   Reset empties both pipeline registers (their payloads are not reset) and
//   clears all registers, the counters and the status interrupt level.
module lcd_scanline_timer_regs_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lcdst_pkg::in_item_t   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lcdst_pkg::out_item_t  out_data
);
    import lcdst_pkg::*;

    logic          in_valid_reg, in_valid_next;
    in_item_t      in_reg;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_reg;
    logic          advance;
    logic          do_tick, do_read, do_write;
    timer_cfg_t    cfg;
    timer_status_t status;
    logic [DATA_W-1:0] rdata;
    logic          vblank_pulse, stat_pulse;

    // Handshake control: execute when the output register is free or draining.
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Command decode for the item being executed.
    always_comb
    begin
        do_tick  = 1'b0;
        do_read  = 1'b0;
        do_write = 1'b0;
        case (in_reg.cmd)
            CMD_TICK:  do_tick  = advance;
            CMD_READ:  do_read  = advance;
            CMD_WRITE: do_write = advance;
            default:   ;
        endcase
    end

    lcdst_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (do_read),
        .wr_en  (do_write),
        .addr   (in_reg.addr),
        .wdata  (in_reg.wdata),
        .status (status),
        .cfg    (cfg),
        .rdata  (rdata)
    );

    lcdst_timer u_timer (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (do_tick),
        .cfg          (cfg),
        .status       (status),
        .vblank_pulse (vblank_pulse),
        .stat_pulse   (stat_pulse)
    );

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_reg <= in_data;
        if (advance)
        begin
            out_reg.rdata      <= rdata;
            out_reg.vblank_irq <= vblank_pulse;
            out_reg.stat_irq   <= stat_pulse;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !advance)
        else $error("result overwritten while stalled");
    a_accept_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> in_valid_reg)
        else $error("accepted item lost");
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({do_tick, do_read, do_write}))
        else $error("more than one action in a cycle");
`endif

endmodule
